@@ rtl/glw_pkg.sv @@
// Package with the types, constants and reset values shared by the line wrapper.
`timescale 1ns / 1ps

package glw_pkg;

   localparam int ROWS_PER_LINE_DEFAULT = 8;
   localparam int LINE_BYTES_DEFAULT    = 4096;

   localparam int CODE_W   = 21;
   localparam int GLYPH_W  = 8;
   localparam int COUNT_W  = 3;
   localparam int WRAP_W   = 12;
   localparam int OFFSET_W = 13;
   localparam int WIDTH_W  = 13;
   localparam int ROWNUM_W = 3;

   localparam logic [WRAP_W-1:0]  WRAP_WIDTH_RESET = 12'd320;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX        = 13'h1FFF;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [CODE_W-1:0] SPACE_CODE = 21'h00020;
   localparam logic [CODE_W-1:0] CJK_LO     = 21'h02E80;
   localparam logic [CODE_W-1:0] CJK_HI     = 21'h09FFF;
   localparam logic [CODE_W-1:0] HANGUL_LO  = 21'h0AC00;
   localparam logic [CODE_W-1:0] HANGUL_HI  = 21'h0D7AF;
   localparam logic [CODE_W-1:0] COMPAT_LO  = 21'h0F900;
   localparam logic [CODE_W-1:0] COMPAT_HI  = 21'h0FAFF;
   localparam logic [CODE_W-1:0] FULL_LO    = 21'h0FF00;
   localparam logic [CODE_W-1:0] FULL_HI    = 21'h0FFEF;

   typedef struct packed {
      logic                req_type;
      logic [CODE_W-1:0]   code_point;
      logic [GLYPH_W-1:0]  glyph_width;
      logic [COUNT_W-1:0]  byte_count;
   } req_item_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] row_start;
      logic [OFFSET_W-1:0] row_length;
      logic [ROWNUM_W-1:0] row_number;
      logic                final_row;
   } rsp_item_type;

   function automatic logic is_open_script(input logic [CODE_W-1:0] cp);
      return (cp >= CJK_LO && cp <= CJK_HI) || (cp >= HANGUL_LO && cp <= HANGUL_HI) ||
             (cp >= COMPAT_LO && cp <= COMPAT_HI) || (cp >= FULL_LO && cp <= FULL_HI);
   endfunction

endpackage

@@ rtl/glw_input_stage.sv @@
// Input register that holds one request until the wrap logic takes it.
`timescale 1ns / 1ps

module glw_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  glw_pkg::req_item_type req_data,
   input  logic                  advance,
   output logic                  item_valid,
   output glw_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   glw_pkg::req_item_type data_ff;
   glw_pkg::req_item_type data_in;
   logic                  load;

   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = load || (valid_ff && !advance);
      data_in  = load ? req_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

@@ rtl/glw_wrap_core.sv @@
// Line state registers and the single-pass wrap decision for one request.
`timescale 1ns / 1ps

module glw_wrap_core #(
   parameter int ROWS_PER_LINE = glw_pkg::ROWS_PER_LINE_DEFAULT,
   parameter int LINE_BYTES    = glw_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [glw_pkg::WRAP_W-1:0]    csr_wr_data,
   input  logic                          fire,
   input  glw_pkg::req_item_type         item,
   output logic                          row_valid,
   output glw_pkg::rsp_item_type         row
);

   localparam int OW = $clog2(LINE_BYTES + 1);
   localparam int RW = (ROWS_PER_LINE > 1) ? $clog2(ROWS_PER_LINE) : 1;
   localparam int WW = glw_pkg::WIDTH_W;
   localparam logic [OW-1:0] LineMax = OW'(LINE_BYTES);
   localparam logic [RW-1:0] LastRow = RW'(ROWS_PER_LINE - 1);

   logic [glw_pkg::WRAP_W-1:0] wrap_width_ff, wrap_width_in;
   logic [OW-1:0]              byte_position_ff, byte_position_in;
   logic [OW-1:0]              row_start_ff, row_start_in;
   logic [WW-1:0]              running_width_ff, running_width_in;
   logic [OW-1:0]              break_position_ff, break_position_in;
   logic [OW-1:0]              break_resume_ff, break_resume_in;
   logic [WW-1:0]              break_width_ff, break_width_in;
   logic                       break_valid_ff, break_valid_in;
   logic [RW-1:0]              rows_ff, rows_in;

   logic [OW:0]   pos_sum;
   logic [OW-1:0] pos_next;
   logic [WW:0]   width_sum;
   logic [WW-1:0] width_sat;
   logic [WW-1:0] width_mid;
   logic [WW:0]   mid_sum;
   logic          is_space;
   logic          past_start;
   logic          split;
   logic          use_break;
   logic [OW-1:0] end_length;
   logic [OW-1:0] split_length;

   always_comb begin
      pos_sum    = {1'b0, byte_position_ff} + (OW + 1)'(item.byte_count);
      pos_next   = (pos_sum > {1'b0, LineMax}) ? LineMax : pos_sum[OW-1:0];
      width_sum  = {1'b0, running_width_ff} + (WW + 1)'(item.glyph_width);
      width_sat  = width_sum[WW] ? glw_pkg::WIDTH_MAX : width_sum[WW-1:0];
      is_space   = (item.code_point == glw_pkg::SPACE_CODE);
      past_start = (byte_position_ff > row_start_ff);
      end_length = (byte_position_ff >= row_start_ff) ?
                   (byte_position_ff - row_start_ff) : '0;

      break_position_in = break_position_ff;
      break_resume_in   = break_resume_ff;
      break_width_in    = break_width_ff;
      break_valid_in    = break_valid_ff;
      if (is_space) begin
         break_position_in = byte_position_ff;
         break_resume_in   = pos_next;
         break_width_in    = width_sat;
         break_valid_in    = 1'b1;
      end else if (glw_pkg::is_open_script(item.code_point) && past_start) begin
         break_position_in = byte_position_ff;
         break_resume_in   = byte_position_ff;
         break_width_in    = running_width_ff;
         break_valid_in    = 1'b1;
      end

      split     = (width_sum > (WW + 1)'(wrap_width_ff)) && past_start &&
                  (rows_ff != LastRow);
      use_break = break_valid_in && (break_position_in > row_start_ff);

      row_start_in = row_start_ff;
      width_mid    = running_width_ff;
      split_length = byte_position_ff - row_start_ff;
      rows_in      = rows_ff;
      if (split) begin
         rows_in        = rows_ff + 1'b1;
         break_valid_in = 1'b0;
         if (use_break) begin
            split_length = break_position_in - row_start_ff;
            row_start_in = break_resume_in;
            width_mid    = (running_width_ff >= break_width_in) ?
                           (running_width_ff - break_width_in) : '0;
         end else begin
            row_start_in = byte_position_ff;
            width_mid    = '0;
         end
      end
      mid_sum          = {1'b0, width_mid} + (WW + 1)'(item.glyph_width);
      running_width_in = mid_sum[WW] ? glw_pkg::WIDTH_MAX : mid_sum[WW-1:0];
      byte_position_in = pos_next;

      row.row_number = glw_pkg::ROWNUM_W'(rows_ff);
      row.row_start  = glw_pkg::OFFSET_W'(row_start_ff);
      if (item.req_type == glw_pkg::REQ_END) begin
         row_valid      = 1'b1;
         row.row_length = glw_pkg::OFFSET_W'(end_length);
         row.final_row  = 1'b1;
      end else begin
         row_valid      = split;
         row.row_length = glw_pkg::OFFSET_W'(split_length);
         row.final_row  = 1'b0;
      end

      wrap_width_in = csr_wr_en ? csr_wr_data : wrap_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_width_ff <= glw_pkg::WRAP_WIDTH_RESET;
      end else begin
         wrap_width_ff <= wrap_width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && item.req_type == glw_pkg::REQ_END)) begin
         byte_position_ff  <= '0;
         row_start_ff      <= '0;
         running_width_ff  <= '0;
         break_position_ff <= '0;
         break_resume_ff   <= '0;
         break_width_ff    <= '0;
         break_valid_ff    <= 1'b0;
         rows_ff           <= '0;
      end else if (fire) begin
         byte_position_ff  <= byte_position_in;
         row_start_ff      <= row_start_in;
         running_width_ff  <= running_width_in;
         break_position_ff <= break_position_in;
         break_resume_ff   <= break_resume_in;
         break_width_ff    <= break_width_in;
         break_valid_ff    <= break_valid_in;
         rows_ff           <= rows_in;
      end
   end

endmodule

@@ rtl/glw_output_stage.sv @@
// Result register that holds one row until the receiver takes it.
`timescale 1ns / 1ps

module glw_output_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  row_valid,
   input  glw_pkg::rsp_item_type row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output glw_pkg::rsp_item_type rsp_data
);

   logic                  valid_ff;
   logic                  valid_in;
   glw_pkg::rsp_item_type data_ff;
   glw_pkg::rsp_item_type data_in;
   logic                  load;

   assign load = fire && row_valid;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_ready);
      data_in  = load ? row : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ rtl/greedy_line_wrapper_unit.sv @@
// Top level of the greedy line wrapper.
//
// Each request carries one decoded character, or an end-of-line marker.
// The block splits the line into up to ROWS_PER_LINE rows where the wrap
// width is passed, and sends one response per row: start offset, length
// in bytes, row number and a final-row flag. A character request gives
// zero or one response; an end request always gives the final row and
// clears the line state. The wrap width is written through csr_wr_en and
// csr_wr_data; the user writes it while the block is idle, which the
// block does not enforce; it resets to 320 pixels. A request passes from
// the input register through the wrap logic into the output register.
// One request is taken every cycle while responses are read; the limit
// is the update of the line state registers. When the receiver stalls,
// the response stays in the output register, one more request waits in
// the input register and req_ready drops until the response is taken.
// Synchronous reset empties both registers and clears the line state.
`timescale 1ns / 1ps

module greedy_line_wrapper_unit #(
   parameter int ROWS_PER_LINE = glw_pkg::ROWS_PER_LINE_DEFAULT,
   parameter int LINE_BYTES    = glw_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  glw_pkg::req_item_type      req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output glw_pkg::rsp_item_type      rsp_data,
   input  logic                       csr_wr_en,
   input  logic [glw_pkg::WRAP_W-1:0] csr_wr_data
);

   logic                  item_valid;
   glw_pkg::req_item_type item;
   logic                  fire;
   logic                  row_valid;
   glw_pkg::rsp_item_type row;

   assign fire = item_valid && (!rsp_valid || rsp_ready);

   glw_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   glw_wrap_core #(
      .ROWS_PER_LINE (ROWS_PER_LINE),
      .LINE_BYTES    (LINE_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .row_valid   (row_valid),
      .row         (row)
   );

   glw_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .row_valid (row_valid),
      .row       (row),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/glw_checker.sv @@
// Port-level checks for the line wrapper and the bind that attaches them.
`timescale 1ns / 1ps

module glw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input glw_pkg::rsp_item_type      rsp_data
);

   // A stalled response keeps its row unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves no response pending and the input side open.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // A row split in mid-line always holds at least one character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.final_row |-> rsp_data.row_length != 13'd0)
      else $error("empty split row");

   // A row never reaches past the end of the line buffer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.row_start} + {1'b0, rsp_data.row_length})
                    <= 14'(glw_pkg::LINE_BYTES_DEFAULT))
      else $error("row extends past the line end");

endmodule

bind greedy_line_wrapper_unit glw_checker u_glw_checker (.*);

@@ verif/tb_greedy_line_wrapper_unit.sv @@
// Self-checking testbench for the greedy line wrapper with a built-in row predictor.
`timescale 1ns / 1ps

module tb_greedy_line_wrapper_unit;

   localparam int LINE_LIMIT    = glw_pkg::LINE_BYTES_DEFAULT;
   localparam int ROW_LIMIT     = glw_pkg::ROWS_PER_LINE_DEFAULT;
   localparam int CODE_BITS     = glw_pkg::CODE_W;
   localparam int GLYPH_BITS    = glw_pkg::GLYPH_W;
   localparam int COUNT_BITS    = glw_pkg::COUNT_W;
   localparam int WRAP_BITS     = glw_pkg::WRAP_W;
   localparam int OFFSET_BITS   = glw_pkg::OFFSET_W;
   localparam int WIDTH_BITS    = glw_pkg::WIDTH_W;
   localparam int ROWNUM_BITS   = glw_pkg::ROWNUM_W;
   localparam int REQ_BITS      = $bits(glw_pkg::req_item_type);
   localparam int RANDOM_TARGET = 1800;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   glw_pkg::req_item_type  req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   glw_pkg::rsp_item_type  rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [WRAP_BITS-1:0]   csr_wr_data = '0;

   // Line state as the wrapper should hold it.
   logic [WRAP_BITS-1:0]   wrap_limit = glw_pkg::WRAP_WIDTH_RESET;
   logic [OFFSET_BITS-1:0] byte_pos = '0;
   logic [OFFSET_BITS-1:0] line_start = '0;
   logic [WIDTH_BITS-1:0]  run_width = '0;
   logic [OFFSET_BITS-1:0] brk_pos = '0;
   logic [OFFSET_BITS-1:0] brk_next = '0;
   logic [WIDTH_BITS-1:0]  brk_run = '0;
   logic                   brk_valid = 1'b0;
   logic [ROWNUM_BITS-1:0] rows_done = '0;

   glw_pkg::req_item_type  pending[$];
   glw_pkg::rsp_item_type  rows_expected[$];

   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned lines_queued = 0;
   int unsigned rows_checked = 0;
   int unsigned final_rows = 0;
   int unsigned wrap_writes = 0;
   int unsigned mismatch_count = 0;
   int unsigned error_count = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned ready_tick = 0;
   int unsigned idle_cycles = 0;

   greedy_line_wrapper_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [OFFSET_BITS-1:0] clip_bytes(input int unsigned value);
      return (value > LINE_LIMIT) ? OFFSET_BITS'(LINE_LIMIT) : OFFSET_BITS'(value);
   endfunction

   function automatic logic [WIDTH_BITS-1:0] clip_width(input int unsigned value);
      return (value > glw_pkg::WIDTH_MAX) ? glw_pkg::WIDTH_MAX : WIDTH_BITS'(value);
   endfunction

   function automatic logic breaks_script(input logic [CODE_BITS-1:0] cp);
      return (cp >= glw_pkg::CJK_LO && cp <= glw_pkg::CJK_HI)
          || (cp >= glw_pkg::HANGUL_LO && cp <= glw_pkg::HANGUL_HI)
          || (cp >= glw_pkg::COMPAT_LO && cp <= glw_pkg::COMPAT_HI)
          || (cp >= glw_pkg::FULL_LO && cp <= glw_pkg::FULL_HI);
   endfunction

   function automatic void predict_rows(input glw_pkg::req_item_type item);
      int unsigned at;
      int unsigned cw;
      int unsigned bc;
      int unsigned total;
      glw_pkg::rsp_item_type row;
      row = '0;
      if (item.req_type == glw_pkg::REQ_END) begin
         row.row_start  = line_start;
         row.row_length = (byte_pos >= line_start) ? byte_pos - line_start : '0;
         row.row_number = rows_done;
         row.final_row  = 1'b1;
         rows_expected.push_back(row);
         byte_pos   = '0;
         line_start = '0;
         run_width  = '0;
         brk_pos    = '0;
         brk_next   = '0;
         brk_run    = '0;
         brk_valid  = 1'b0;
         rows_done  = '0;
      end else begin
         at = byte_pos;
         cw = item.glyph_width;
         bc = item.byte_count;
         if (item.code_point == glw_pkg::SPACE_CODE) begin
            brk_pos   = OFFSET_BITS'(at);
            brk_next  = clip_bytes(at + bc);
            brk_run   = clip_width(run_width + cw);
            brk_valid = 1'b1;
         end else if (breaks_script(item.code_point) && at > line_start) begin
            brk_pos   = OFFSET_BITS'(at);
            brk_next  = OFFSET_BITS'(at);
            brk_run   = run_width;
            brk_valid = 1'b1;
         end
         total = run_width + cw;
         if (total > wrap_limit && at > line_start && int'(rows_done) + 1 < ROW_LIMIT) begin
            row.row_start  = line_start;
            row.row_number = rows_done;
            row.final_row  = 1'b0;
            if (brk_valid && brk_pos > line_start) begin
               row.row_length = brk_pos - line_start;
               line_start     = brk_next;
               run_width      = (run_width >= brk_run) ? run_width - brk_run : '0;
            end else begin
               row.row_length = OFFSET_BITS'(at) - line_start;
               line_start     = OFFSET_BITS'(at);
               run_width      = '0;
            end
            rows_done = rows_done + 1'b1;
            brk_valid = 1'b0;
            rows_expected.push_back(row);
         end
         run_width = clip_width(run_width + cw);
         byte_pos  = clip_bytes(at + bc);
      end
   endfunction

   function automatic void queue_item(input glw_pkg::req_item_type item);
      pending.push_back(item);
      queued_count++;
      if (item.req_type == glw_pkg::REQ_END) lines_queued++;
   endfunction

   function automatic glw_pkg::req_item_type random_char();
      glw_pkg::req_item_type c;
      int unsigned pick;
      logic [CODE_BITS-1:0] edges_of_ranges[16];
      edges_of_ranges = '{glw_pkg::CJK_LO - 1'b1, glw_pkg::CJK_LO,
                          glw_pkg::CJK_HI, glw_pkg::CJK_HI + 1'b1,
                          glw_pkg::HANGUL_LO - 1'b1, glw_pkg::HANGUL_LO,
                          glw_pkg::HANGUL_HI, glw_pkg::HANGUL_HI + 1'b1,
                          glw_pkg::COMPAT_LO - 1'b1, glw_pkg::COMPAT_LO,
                          glw_pkg::COMPAT_HI, glw_pkg::COMPAT_HI + 1'b1,
                          glw_pkg::FULL_LO - 1'b1, glw_pkg::FULL_LO,
                          glw_pkg::FULL_HI, glw_pkg::FULL_HI + 1'b1};
      c.req_type = glw_pkg::REQ_CHAR;
      pick = $urandom_range(0, 99);
      if (pick < 20) c.code_point = glw_pkg::SPACE_CODE;
      else if (pick < 28)
         c.code_point = CODE_BITS'($urandom_range(glw_pkg::CJK_LO, glw_pkg::CJK_HI));
      else if (pick < 33)
         c.code_point = CODE_BITS'($urandom_range(glw_pkg::HANGUL_LO, glw_pkg::HANGUL_HI));
      else if (pick < 36)
         c.code_point = CODE_BITS'($urandom_range(glw_pkg::COMPAT_LO, glw_pkg::COMPAT_HI));
      else if (pick < 39)
         c.code_point = CODE_BITS'($urandom_range(glw_pkg::FULL_LO, glw_pkg::FULL_HI));
      else if (pick < 45) c.code_point = edges_of_ranges[$urandom_range(0, 15)];
      else if (pick < 55) c.code_point = CODE_BITS'($urandom);
      else c.code_point = CODE_BITS'($urandom_range(21'h21, 21'h7E));
      pick = $urandom_range(0, 99);
      if (pick < 10) c.glyph_width = '0;
      else if (pick < 15) c.glyph_width = '1;
      else if (pick < 25) c.glyph_width = GLYPH_BITS'($urandom);
      else c.glyph_width = GLYPH_BITS'($urandom_range(1, 40));
      c.byte_count = ($urandom_range(0, 99) < 85) ? COUNT_BITS'($urandom_range(1, 4))
                                                  : COUNT_BITS'($urandom);
      return c;
   endfunction

   task automatic set_wrap_width(input logic [WRAP_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      wrap_limit   = value;
      wrap_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every request has gone in and every row has come out, then lets
   // the pipeline drain requests that produce no row.
   task automatic wait_idle();
      while (pending.size() != 0 || accepted_count != queued_count || rows_expected.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_rows(req_data);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rows_expected.size() == 0) begin
               error_count++;
               $display("Unexpected row: start %0d len %0d num %0d final %0d",
                        rsp_data.row_start, rsp_data.row_length,
                        rsp_data.row_number, rsp_data.final_row);
            end else begin
               if (rsp_data.row_start !== rows_expected[0].row_start
                   || rsp_data.row_length !== rows_expected[0].row_length
                   || rsp_data.row_number !== rows_expected[0].row_number
                   || rsp_data.final_row !== rows_expected[0].final_row) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("Row mismatch: expected start %0d len %0d num %0d final %0d",
                              rows_expected[0].row_start, rows_expected[0].row_length,
                              rows_expected[0].row_number, rows_expected[0].final_row);
                     $display("              got start %0d len %0d num %0d final %0d",
                              rsp_data.row_start, rsp_data.row_length,
                              rsp_data.row_number, rsp_data.final_row);
                  end
               end
               if (rows_expected[0].final_row) final_rows++;
               rows_checked++;
               void'(rows_expected.pop_front());
            end
         end
         ready_tick++;
         case (ready_tick[9:7])
            3'd0, 3'd1: rsp_ready <= 1'b1;
            3'd2, 3'd3: rsp_ready <= 1'($urandom_range(0, 1));
            3'd4:       rsp_ready <= (ready_tick[1:0] == 2'd0);
            3'd5:       rsp_ready <= (ready_tick[4:0] > 5'd19);
            3'd6:       rsp_ready <= ($urandom_range(0, 9) != 0);
            default:    rsp_ready <= ready_tick[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or row moved for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned directed_count;
      int unsigned char_total;
      logic [WRAP_BITS-1:0] width_pick;
      glw_pkg::req_item_type item;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset wrap width: empty line, then a wide glyph that splits before it.
      queue_item('{glw_pkg::REQ_END, '1, '1, '1});
      queue_item('{glw_pkg::REQ_CHAR, '1, 8'd255, 3'd7});
      queue_item('{glw_pkg::REQ_CHAR, 21'h41, 8'd255, 3'd0});
      queue_item('{glw_pkg::REQ_END, 21'h0, 8'd0, 3'd0});
      wait_idle();

      set_wrap_width(12'd20);
      // Break at a space whose width stays with the broken row.
      queue_item('{glw_pkg::REQ_CHAR, 21'h61, 8'd10, 3'd1});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::SPACE_CODE, 8'd5, 3'd1});
      queue_item('{glw_pkg::REQ_CHAR, 21'h62, 8'd10, 3'd2});
      queue_item('{glw_pkg::REQ_END, 21'h0, 8'd0, 3'd0});
      // Wide-script characters at both ends of every range.
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::CJK_LO, 8'd15, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::CJK_HI, 8'd15, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::HANGUL_LO, 8'd5, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::HANGUL_HI, 8'd1, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::COMPAT_LO, 8'd30, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::COMPAT_HI, 8'd0, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::FULL_LO, 8'd25, 3'd3});
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::FULL_HI, 8'd25, 3'd3});
      queue_item('{glw_pkg::REQ_END, 21'h0, 8'd0, 3'd0});
      // A space at the row start is no break point.
      queue_item('{glw_pkg::REQ_CHAR, glw_pkg::SPACE_CODE, 8'd15, 3'd1});
      queue_item('{glw_pkg::REQ_CHAR, 21'h63, 8'd10, 3'd1});
      queue_item('{glw_pkg::REQ_END, 21'h0, 8'd0, 3'd0});
      wait_idle();
      directed_count = queued_count;

      phase = 0;
      while (queued_count - directed_count < RANDOM_TARGET) begin
         case (phase)
            0: width_pick = '0;
            1: width_pick = '1;
            2: width_pick = glw_pkg::WRAP_WIDTH_RESET;
            default: begin
               case ($urandom_range(0, 3))
                  0: width_pick = WRAP_BITS'($urandom_range(1, 60));
                  1: width_pick = WRAP_BITS'($urandom_range(61, 600));
                  2: width_pick = WRAP_BITS'($urandom);
                  default: width_pick = $urandom_range(0, 1) ? '0 : '1;
               endcase
            end
         endcase
         set_wrap_width(width_pick);
         if (phase == 1) begin
            // One line long enough to saturate the byte offsets.
            repeat (600) begin
               item = random_char();
               item.glyph_width = ($urandom_range(0, 19) == 0) ?
                                  GLYPH_BITS'($urandom_range(1, 5)) : '0;
               item.byte_count  = 3'd7;
               queue_item(item);
            end
            item = random_char();
            item.req_type = glw_pkg::REQ_END;
            queue_item(item);
         end
         char_total = queued_count;
         while (queued_count - char_total < 150) begin
            repeat (($urandom_range(0, 6) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 30))
               queue_item(random_char());
            item = REQ_BITS'({$urandom, $urandom});
            item.req_type = glw_pkg::REQ_END;
            queue_item(item);
         end
         wait_idle();
         phase++;
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (rows_expected.size() != 0) begin
         error_count += rows_expected.size();
         $display("%0d expected rows never arrived", rows_expected.size());
      end
      $display("Sent %0d requests over %0d lines under %0d wrap width settings.",
               accepted_count, lines_queued, wrap_writes + 1);
      $display("Checked %0d rows, %0d of them final, with %0d mismatches and %0d stray rows.",
               rows_checked, final_rows, mismatch_count, error_count);
      if (mismatch_count == 0 && error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
